// File: rtl/esf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_pkg: shared types and constants of the encoder speed filter
// Payload structs, controller command and status bundles, register indexes.
// ----------------------------------------------------------------------------
package esf_pkg;

  localparam int AVG_DEPTH  = 5;
  localparam int CNT_W      = 32;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 24;
  localparam int TALLY_W    = 4;
  localparam int CPR_W      = 11;
  localparam int SCALE_W    = 20;
  localparam int PROD_W     = CNT_W + SCALE_W;
  localparam int SUM_W      = RATE_W + $clog2(AVG_DEPTH);
  localparam int POS_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int DIV_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Ring mean as sum * ceil(2^MEAN_SHIFT / depth) >> MEAN_SHIFT; the shift
  // leaves enough headroom that the rounding error never reaches one unit.
  localparam int MEAN_SHIFT = SUM_W + $clog2(AVG_DEPTH);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int MPROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 3'd4;

  // Register reset values
  localparam logic [CPR_W-1:0]   CPR_RESET     = 11'd6;
  localparam logic [CNT_W-1:0]   CLIMIT_RESET  = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0]  MININT_RESET  = 32'd95000;
  localparam logic [TALLY_W-1:0] REJLIM_RESET  = 4'd2;
  localparam logic [TALLY_W-1:0] WINLEN_RESET  = 4'd10;

  typedef struct packed {
    logic [CNT_W-1:0]  count_now;
    logic [TIME_W-1:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic               processed;
    logic               accepted;
    logic [RATE_W-1:0]  raw_rate;
    logic [RATE_W-1:0]  avg_rate;
    logic               overspeed;
    logic [TALLY_W-1:0] rejects;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic prime;
    logic load_delta;
    logic mul;
    logic div_raw;
    logic raw_sat;
    logic raw_take;
    logic update;
    logic mean_take;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic primed;
    logic interval_ok;
    logic ovf;
    logic div_busy;
    logic took;
    logic out_full;
  } dp_status_t;

endpackage

// File: rtl/esf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_div: restoring divider, one quotient bit per cycle
// Divides {rem_init, lo_init} by den; rem_init must be below den, so the
// quotient fits RATE_W bits.
// ----------------------------------------------------------------------------
module esf_div
  import esf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  rem_init_i,
  input  logic [RATE_W-1:0] lo_init_i,
  input  logic [DIV_W-1:0]  den_i,
  output logic              busy_o,
  output logic [RATE_W-1:0] quo_o
);

  localparam int STEP_W = $clog2(RATE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_W - 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [RATE_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]  den_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, quo_q[RATE_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    quo_d = {quo_q[RATE_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      quo_q <= lo_init_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/esf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_dp: datapath of the encoder speed filter
// Config registers, sample registers, rate multiply and divide, averaging
// ring with running sum, tallies and the output register.
// ----------------------------------------------------------------------------
module esf_dp
  import esf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  output out_item_t             out_data_o,
  input  logic                  out_stall_i
);

  // floor(250 * cpr / 60) = floor(floor(25 * cpr / 2) / 3), /3 by reciprocal
  function automatic logic [RATE_W-1:0] band_of(input logic [CPR_W-1:0] cpr);
    logic [15:0] x25;
    logic [31:0] prod;
    x25  = 16'(cpr) * 16'd25;
    prod = 32'(x25[15:1]) * 32'd43691;
    return RATE_W'(prod[31:17]);
  endfunction

  // floor(3150 * cpr / 60) = floor(105 * cpr / 2)
  function automatic logic [RATE_W-1:0] limit_of(input logic [CPR_W-1:0] cpr);
    logic [17:0] x105;
    x105 = 18'(cpr) * 18'd105;
    return RATE_W'(x105[17:1]);
  endfunction

  logic [CPR_W-1:0]   cpr_q;
  logic [CNT_W-1:0]   climit_q;
  logic [TIME_W-1:0]  minint_q;
  logic [TALLY_W-1:0] rejlim_q;
  logic [TALLY_W-1:0] winlen_q;
  logic [RATE_W-1:0]  band_q;
  logic [RATE_W-1:0]  limit_q;

  logic               primed_q;
  logic [CNT_W-1:0]   prev_count_q;
  logic [TIME_W-1:0]  prev_time_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TIME_W-1:0]  time_q;
  logic [TIME_W-1:0]  interval_q;
  logic [CNT_W-1:0]   delta_q;
  logic [PROD_W-1:0]  prod_q;
  logic [RATE_W-1:0]  raw_q;
  logic [RATE_W-1:0]  mean_q;
  logic [RATE_W-1:0]  ring_q [AVG_DEPTH];
  logic [POS_W-1:0]   pos_q;
  logic [SUM_W-1:0]   sum_q;
  logic [TALLY_W-1:0] rej_q;
  logic [TALLY_W-1:0] win_q;
  logic               proc_q;
  logic               took_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [TIME_W-1:0]  interval;
  logic               interval_ok;
  logic [CNT_W-1:0]   gap;
  logic [CNT_W-1:0]   delta;
  logic               ovf;
  logic [RATE_W-1:0]  diff;
  logic               took;
  logic [TALLY_W-1:0] rej_inc;
  logic [TALLY_W-1:0] win_inc;
  logic [TALLY_W-1:0] rej_d;
  logic [TALLY_W-1:0] win_d;
  logic [POS_W-1:0]   pos_d;
  logic [SUM_W-1:0]   sum_d;
  logic [MPROD_W-1:0] mean_prod;
  logic               div_start;
  logic [DIV_W-1:0]   div_rem;
  logic [RATE_W-1:0]  div_lo;
  logic [DIV_W-1:0]   div_den;
  logic               div_busy;
  logic [RATE_W-1:0]  div_quo;

  // Config registers; band and limit are registered from cpr in the cycle after it changes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q    <= CPR_RESET;
      climit_q <= CLIMIT_RESET;
      minint_q <= MININT_RESET;
      rejlim_q <= REJLIM_RESET;
      winlen_q <= WINLEN_RESET;
      band_q   <= band_of(CPR_RESET);
      limit_q  <= limit_of(CPR_RESET);
    end else begin
      band_q  <= band_of(cpr_q);
      limit_q <= limit_of(cpr_q);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COUNTS_PER_REV: cpr_q    <= cfg_data_i[CPR_W-1:0];
          CFG_COUNT_LIMIT:    climit_q <= cfg_data_i[CNT_W-1:0];
          CFG_MIN_INTERVAL:   minint_q <= cfg_data_i[TIME_W-1:0];
          CFG_REJECT_LIMIT:   rejlim_q <= cfg_data_i[TALLY_W-1:0];
          CFG_WINDOW_LEN:     winlen_q <= cfg_data_i[TALLY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Interval and wrapped count delta
  always_comb begin
    interval    = time_q - prev_time_q;
    interval_ok = (interval > minint_q) && (interval != '0);
    gap         = prev_count_q - cnt_q;
    if (cnt_q >= prev_count_q) begin
      delta = cnt_q - prev_count_q;
    end else if (climit_q >= gap) begin
      delta = climit_q - gap;
    end else begin
      delta = '0;
    end
  end

  // Quotient saturates when the upper product bits reach the interval
  assign ovf = (DIV_W'(prod_q[PROD_W-1:RATE_W]) >= interval_q);

  // Glitch test, tallies and ring update
  always_comb begin
    diff    = (raw_q > mean_q) ? (raw_q - mean_q) : (mean_q - raw_q);
    took    = (diff < band_q) || (rej_q >= rejlim_q);
    rej_inc = (!took && (rej_q != '1)) ? (rej_q + 1'b1) : rej_q;
    win_inc = win_q + 1'b1;
    if (win_inc >= winlen_q) begin
      win_d = '0;
      rej_d = '0;
    end else begin
      win_d = win_inc;
      rej_d = rej_inc;
    end
    pos_d = (pos_q == POS_W'(AVG_DEPTH - 1)) ? '0 : (pos_q + 1'b1);
    sum_d = sum_q - SUM_W'(ring_q[pos_d]) + SUM_W'(raw_q);
  end

  // Ring sum divided by the depth through the reciprocal
  assign mean_prod = MPROD_W'(sum_q) * MPROD_W'(MEAN_RECIP);

  assign div_start = cmd_i.div_raw;
  assign div_rem   = DIV_W'(prod_q[PROD_W-1:RATE_W]);
  assign div_lo    = prod_q[RATE_W-1:0];
  assign div_den   = interval_q;

  esf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .lo_init_i  (div_lo),
    .den_i      (div_den),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      prev_count_q <= '0;
      prev_time_q  <= '0;
      raw_q        <= '0;
      mean_q       <= '0;
      pos_q        <= '0;
      sum_q        <= '0;
      rej_q        <= '0;
      win_q        <= '0;
      proc_q       <= 1'b0;
      took_q       <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        proc_q <= 1'b0;
        took_q <= 1'b0;
      end
      if (cmd_i.prime) begin
        primed_q     <= 1'b1;
        prev_count_q <= cnt_q;
        prev_time_q  <= time_q;
      end
      if (cmd_i.load_delta) begin
        prev_count_q <= cnt_q;
        prev_time_q  <= time_q;
        proc_q       <= 1'b1;
      end
      if (cmd_i.raw_sat) begin
        raw_q <= '1;
      end
      if (cmd_i.raw_take) begin
        raw_q <= div_quo;
      end
      if (cmd_i.update) begin
        took_q <= took;
        rej_q  <= rej_d;
        win_q  <= win_d;
        if (took) begin
          pos_q         <= pos_d;
          sum_q         <= sum_d;
          ring_q[pos_d] <= raw_q;
        end
      end
      if (cmd_i.mean_take) begin
        mean_q <= mean_prod[MEAN_SHIFT +: RATE_W];
      end
    end
  end

  // Sample, interval and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cnt_q  <= in_data_i.count_now;
      time_q <= in_data_i.time_now;
    end
    if (cmd_i.load_delta) begin
      interval_q <= interval;
      delta_q    <= delta;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(delta_q) * PROD_W'(US_PER_S);
    end
  end

  // Output register: load frees the core, drop when the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.processed <= proc_q;
      out_q.accepted  <= took_q;
      out_q.raw_rate  <= raw_q;
      out_q.avg_rate  <= mean_q;
      out_q.overspeed <= (mean_q > limit_q);
      out_q.rejects   <= rej_q;
    end
  end

  assign status_o.primed      = primed_q;
  assign status_o.interval_ok = interval_ok;
  assign status_o.ovf         = ovf;
  assign status_o.div_busy    = div_busy;
  assign status_o.took        = took;
  assign status_o.out_full    = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/esf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_ctrl: sequencer of the encoder speed filter
// Walks one sample through check, multiply, divide, update and mean.
// ----------------------------------------------------------------------------
module esf_ctrl
  import esf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DIVR   = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_MEAN   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status_i.primed) begin
          cmd_o.prime = 1'b1;
          state_d     = S_FIN;
        end else if (!status_i.interval_ok) begin
          state_d = S_FIN;
        end else begin
          cmd_o.load_delta = 1'b1;
          state_d          = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DSTART;
      end
      S_DSTART: begin
        if (status_i.ovf) begin
          cmd_o.raw_sat = 1'b1;
          state_d       = S_UPD;
        end else begin
          cmd_o.div_raw = 1'b1;
          state_d       = S_DIVR;
        end
      end
      S_DIVR: begin
        if (!status_i.div_busy) begin
          cmd_o.raw_take = 1'b1;
          state_d        = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.took ? S_MEAN : S_FIN;
      end
      S_MEAN: begin
        cmd_o.mean_take = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/encoder_speed_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_filter: rolling-average speed estimator with glitch rejection
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_data_i  (in_item_t)
//   out      output     out_valid_o/out_stall_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample at a time. A priming or too-early sample goes through check and
// finish only. A processed sample runs check, multiply, the 24-step restoring
// divider for the rate quotient, update and, when its rate enters the ring,
// the mean; the ring mean is one reciprocal multiply. A saturated rate skips
// the divider. A stalled output adds its stall.
// The output register lets the next sample in while a result waits.
// Reset clears the ring, tallies and state and loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_speed_filter
  import esf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  esf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  esf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // The core is busy in the cycle after it takes a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core took a second transaction back to back");

  // A rate can only enter the ring from a processed sample
  a_accepted_needs_processed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted) |-> out_data_o.processed)
    else $error("accepted result without processed");

  // A new result only comes out of a busy core
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in work");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the encoder speed filter
// A directed table of samples, then phases of random samples under several
// register settings. Each accepted sample is run through a bench-side speed
// model. Every output transaction is compared field by field against the
// oldest expected result. The input idles and the output stalls in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import esf_pkg::*;

  localparam int       DIR_ROWS       = 17;
  localparam int       WATCHDOG_LIMIT = 2000;
  localparam int       DRAIN_CYCLES   = 80;
  localparam int       BAND_RPM       = 250;
  localparam int       OVER_RPM       = 3150;
  localparam longint   RATE_MAX       = 64'hFF_FFFF;
  localparam out_item_t IDLE_RESULT   = '0;

  typedef struct {
    logic [CNT_W-1:0]  count_now;
    logic [TIME_W-1:0] time_now;
    bit                typed;
    out_item_t         want;
  } stim_row_t;

  typedef struct {
    logic [CPR_W-1:0]   cpr;
    logic [CNT_W-1:0]   climit;
    logic [TIME_W-1:0]  minint;
    logic [TALLY_W-1:0] rejlim;
    logic [TALLY_W-1:0] winlen;
    int                 items;
  } phase_cfg_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  encoder_speed_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Speed model: registers and state
  logic [CPR_W-1:0]   m_cpr    = CPR_RESET;
  logic [CNT_W-1:0]   m_climit = CLIMIT_RESET;
  logic [TIME_W-1:0]  m_minint = MININT_RESET;
  logic [TALLY_W-1:0] m_rejlim = REJLIM_RESET;
  logic [TALLY_W-1:0] m_winlen = WINLEN_RESET;

  bit                 m_primed = 1'b0;
  logic [CNT_W-1:0]   m_prev_count = '0;
  logic [TIME_W-1:0]  m_prev_time = '0;
  logic [RATE_W-1:0]  m_ring [AVG_DEPTH];
  int unsigned        m_pos = 0;
  logic [RATE_W-1:0]  m_mean = '0;
  logic [RATE_W-1:0]  m_last_raw = '0;
  logic [TALLY_W-1:0] m_rejects = '0;
  logic [TALLY_W-1:0] m_window = '0;

  out_item_t   pending_results [$];
  int          error_count = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [31:0] gen_count, gen_time;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{32'd100,        32'd1000,       1'b1, IDLE_RESULT},  // priming sample
    '{32'd200,        32'd50000,      1'b1, IDLE_RESULT},  // too early
    '{32'd200,        32'd96000,      1'b1, IDLE_RESULT},  // exactly min_interval
    '{32'd300,        32'd96001,      1'b0, IDLE_RESULT},
    '{32'd400,        32'd200000,     1'b0, IDLE_RESULT},
    '{32'd500,        32'd300000,     1'b0, IDLE_RESULT},
    '{32'd600,        32'd400000,     1'b0, IDLE_RESULT},
    '{32'd620,        32'd500000,     1'b0, IDLE_RESULT},
    '{32'd640,        32'd600000,     1'b0, IDLE_RESULT},
    '{32'd640,        32'd700000,     1'b0, IDLE_RESULT},  // zero delta
    '{32'd50,         32'd800000,     1'b0, IDLE_RESULT},  // counter wrap, saturates
    '{32'hFFFF_FFFF,  32'hFFFF_FF00,  1'b0, IDLE_RESULT},
    '{32'd0,          32'h0002_0000,  1'b0, IDLE_RESULT},  // time wraps, delta 0
    '{32'd0,          32'd0,          1'b0, IDLE_RESULT},
    '{32'h7FFF_FFFF,  32'h0003_0000,  1'b0, IDLE_RESULT},
    '{32'h8000_0000,  32'h0005_0000,  1'b0, IDLE_RESULT},
    '{32'h8000_0010,  32'h0007_0000,  1'b0, IDLE_RESULT}
  };

  phase_cfg_t phases [5] = '{
    '{11'd6,    32'hFFFF_FFFF, 32'd95000,     4'd2,  4'd10, 80},
    '{11'd1,    32'd1,         32'd1,         4'd0,  4'd1,  70},
    '{11'd1024, 32'd1000,      32'd1000,      4'd15, 4'd15, 70},
    '{11'd0,    32'h0001_0000, 32'd50000,     4'd3,  4'd0,  70},
    '{11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1,  4'd7,  20}
  };

  function automatic longint speed_limit(input int rpm);
    return (longint'(rpm) * longint'(m_cpr)) / 60;
  endfunction

  task automatic speed_model_step(input in_item_t s, output out_item_t r);
    logic [TIME_W-1:0] span;
    longint            delta, quot, sum, diff;
    bit                done, took;
    done = 1'b0;
    took = 1'b0;
    if (!m_primed) begin
      m_primed     = 1'b1;
      m_prev_count = s.count_now;
      m_prev_time  = s.time_now;
    end else begin
      span = s.time_now - m_prev_time;
      if (span > m_minint && span != 0) begin
        done  = 1'b1;
        delta = longint'(s.count_now) - longint'(m_prev_count);
        if (delta < 0) delta += longint'(m_climit);
        if (delta < 0) delta = 0;
        m_prev_count = s.count_now;
        m_prev_time  = s.time_now;
        quot = (delta * 1000000) / longint'(span);
        m_last_raw = (quot > RATE_MAX) ? RATE_MAX[RATE_W-1:0] : quot[RATE_W-1:0];
        diff = (m_last_raw > m_mean) ? longint'(m_last_raw) - longint'(m_mean)
                                     : longint'(m_mean) - longint'(m_last_raw);
        took = (diff < speed_limit(BAND_RPM)) || (m_rejects >= m_rejlim);
        if (took) begin
          m_pos = m_pos + 1;
          if (m_pos >= AVG_DEPTH) m_pos = 0;
          m_ring[m_pos] = m_last_raw;
          sum = 0;
          foreach (m_ring[i]) sum += longint'(m_ring[i]);
          m_mean = RATE_W'(sum / AVG_DEPTH);
        end else if (m_rejects != 4'd15) begin
          m_rejects = m_rejects + 1'b1;
        end
        m_window = m_window + 1'b1;
        if (m_window >= m_winlen) begin
          m_window  = '0;
          m_rejects = '0;
        end
      end
    end
    r.processed = done;
    r.accepted  = took;
    r.raw_rate  = m_last_raw;
    r.avg_rate  = m_mean;
    r.overspeed = longint'(m_mean) > speed_limit(OVER_RPM);
    r.rejects   = m_rejects;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COUNTS_PER_REV: m_cpr    = data[CPR_W-1:0];
      CFG_COUNT_LIMIT:    m_climit = data;
      CFG_MIN_INTERVAL:   m_minint = data;
      CFG_REJECT_LIMIT:   m_rejlim = data[TALLY_W-1:0];
      CFG_WINDOW_LEN:     m_winlen = data[TALLY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_sample(input in_item_t s, input bit typed, input out_item_t want);
    out_item_t pred;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = s;
    do @(posedge clk_i); while (in_stall_o);
    speed_model_step(s, pred);
    pending_results.push_back(typed ? want : pred);
    gen_count = s.count_now;
    gen_time  = s.time_now;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input phase_cfg_t p, input bit quiet);
    in_item_t    s;
    int unsigned k, rate;
    logic [31:0] span;
    longint      delta;
    drain_results();
    write_reg(CFG_COUNTS_PER_REV, 32'(p.cpr));
    write_reg(CFG_COUNT_LIMIT, p.climit);
    write_reg(CFG_MIN_INTERVAL, p.minint);
    write_reg(CFG_REJECT_LIMIT, 32'(p.rejlim));
    write_reg(CFG_WINDOW_LEN, 32'(p.winlen));
    calm = quiet;
    rate = $urandom_range(0, 200000);
    for (int n = 0; n < p.items; n++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        s.count_now = $urandom;
        s.time_now  = $urandom;
      end else if (k < 18) begin
        // arrives before min_interval in most settings
        s.time_now  = gen_time + $urandom_range(0, 64);
        s.count_now = gen_count + $urandom_range(0, 8);
      end else begin
        if (p.minint > 32'hFFFF_0000) span = $urandom;
        else span = p.minint + $urandom_range(1, 3000);
        if (k < 28) delta = $urandom_range(0, 1 << 20);  // glitch
        else delta = (longint'(rate) * longint'(span)) / 1000000 + $urandom_range(0, 3);
        s.time_now = gen_time + span;
        if (p.climit == 0) s.count_now = 32'(longint'(gen_count) + delta);
        else s.count_now = 32'((longint'(gen_count) + delta) % longint'(p.climit));
      end
      send_sample(s, 1'b0, IDLE_RESULT);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Output stall in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall_i = 1'b1;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Compare every output transaction with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", out_data_o));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.processed !== want.processed)
          report_mismatch($sformatf("processed %0b, want %0b", out_data_o.processed,
                                    want.processed));
        if (out_data_o.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0b, want %0b", out_data_o.accepted,
                                    want.accepted));
        if (out_data_o.raw_rate !== want.raw_rate)
          report_mismatch($sformatf("raw_rate %0d, want %0d", out_data_o.raw_rate,
                                    want.raw_rate));
        if (out_data_o.avg_rate !== want.avg_rate)
          report_mismatch($sformatf("avg_rate %0d, want %0d", out_data_o.avg_rate,
                                    want.avg_rate));
        if (out_data_o.overspeed !== want.overspeed)
          report_mismatch($sformatf("overspeed %0b, want %0b", out_data_o.overspeed,
                                    want.overspeed));
        if (out_data_o.rejects !== want.rejects)
          report_mismatch($sformatf("rejects %0d, want %0d", out_data_o.rejects,
                                    want.rejects));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL encoder_speed_filter");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    phase_cfg_t p;
    in_item_t   s;
    foreach (m_ring[i]) m_ring[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      s.count_now = dir_rows[i].count_now;
      s.time_now  = dir_rows[i].time_now;
      send_sample(s, dir_rows[i].typed, dir_rows[i].want);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // Writes to indexes past the register map must be ignored
    drain_results();
    for (int i = CFG_WINDOW_LEN + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom);

    foreach (phases[i]) run_phase(phases[i], 1'b0);

    for (int i = 0; i < 2; i++) begin
      p.cpr    = CPR_W'($urandom_range(1, 1024));
      p.climit = $urandom;
      p.minint = $urandom_range(1, 200000);
      p.rejlim = TALLY_W'($urandom_range(0, 15));
      p.winlen = TALLY_W'($urandom_range(0, 15));
      p.items  = (i == 0) ? 70 : 80;
      run_phase(p, i == 1);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("PASS encoder_speed_filter");
    end else begin
      $display("FAIL encoder_speed_filter");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/esf_pkg.sv
rtl/esf_div.sv
rtl/esf_dp.sv
rtl/esf_ctrl.sv
rtl/encoder_speed_filter.sv
sim/tb_top.sv
